FILE: src/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

	localparam int COORD_BITS  = 16;
	localparam int COLOR_W     = 24;
	localparam int CNT_W       = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COORD_BITS-1:0] MIN_WIDTH   = COORD_BITS'(4);
	localparam logic [7:0]            ALPHA_BYTE  = 8'hff;
	localparam logic [7:0]            REPEAT_FLAG = 8'h80;
	localparam logic [7:0]            COUNT_MASK  = 8'h7f;

	// configuration register indexes
	localparam logic [1:0] REG_RLE_MODE   = 2'd0;
	localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
	localparam logic [1:0] REG_LINE_COUNT = 2'd2;

	localparam logic [COORD_BITS-1:0] RST_LINE_WIDTH = COORD_BITS'(256);
	localparam logic [COORD_BITS-1:0] RST_LINE_COUNT = COORD_BITS'(256);

	// one run command from the front to the back, one per accepted byte that needs one
	typedef struct packed {
		logic               clr;
		logic               has_px;
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   count;
	} cmd_t;

endpackage

`default_nettype wire

FILE: src/tga_rle_pixel_decoder_unit.sv
// path: queue entry, back end run registers, then the output register
// throughput: one byte per cycle while the 4-entry command queue has room; the back end
// gives one segment per cycle unless out_stall holds it, one per line a run touches
// reset: asynchronous, clears position, packet state, queue and output register;
// rle_mode returns to 1, line_width and line_count to 256
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// 24-bit TGA pixel data decoder (raw or run-length) producing line-clipped runs.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [15:0]                       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              new_image,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [31:0]                            pixel_color,
	output logic [7:0]                             run_length,
	output logic [trd_pkg::COORD_BITS-1:0]         x_start,
	output logic [trd_pkg::COORD_BITS-1:0]         row_index,
	output logic                                   end_of_line,
	output logic                                   end_of_image,
	output logic                                   last_result
);

	logic                                rle_mode_q;
	logic [trd_pkg::COORD_BITS-1:0]      line_width_q;
	logic [trd_pkg::COORD_BITS-1:0]      line_count_q;

	logic                                push;
	trd_pkg::cmd_t                       push_cmd;
	logic                                pop;
	trd_pkg::cmd_t                       head_cmd;
	logic                                q_full;
	logic                                q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q   <= 1'b1;
			line_width_q <= trd_pkg::RST_LINE_WIDTH;
			line_count_q <= trd_pkg::RST_LINE_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				trd_pkg::REG_RLE_MODE:   rle_mode_q   <= cfg_data[0];
				trd_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[trd_pkg::COORD_BITS-1:0];
				trd_pkg::REG_LINE_COUNT: line_count_q <= cfg_data[trd_pkg::COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	trd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rle_mode  (rle_mode_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.new_image (new_image),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	trd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	trd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_width   (line_width_q),
		.line_count   (line_count_q),
		.q_empty      (q_empty),
		.q_head       (head_cmd),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_color  (pixel_color),
		.run_length   (run_length),
		.x_start      (x_start),
		.row_index    (row_index),
		.end_of_line  (end_of_line),
		.end_of_image (end_of_image),
		.last_result  (last_result)
	);

endmodule

`default_nettype wire

FILE: src/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front
// Byte front end: packet headers, pixel byte gathering, run commands.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rle_mode,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    data_byte,
	input  wire logic          new_image,
	input  wire logic          q_full,
	output logic               push,
	output trd_pkg::cmd_t      push_cmd
);

	logic                              hdr_q;
	logic [trd_pkg::CNT_W-1:0]         lit_q;
	logic [trd_pkg::CNT_W-1:0]         rep_q;
	logic [1:0]                        phase_q;
	logic [trd_pkg::COLOR_W-1:0]       gather_q;

	logic                              hdr_c;
	logic [trd_pkg::CNT_W-1:0]         lit_c;
	logic [trd_pkg::CNT_W-1:0]         rep_c;
	logic [1:0]                        phase_c;
	logic [trd_pkg::COLOR_W-1:0]       gather_c;
	logic                              hdr_d;
	logic [trd_pkg::CNT_W-1:0]         lit_d;
	logic [trd_pkg::CNT_W-1:0]         rep_d;
	logic [1:0]                        phase_d;
	logic [trd_pkg::COLOR_W-1:0]       gather_d;
	logic                              px;
	logic [trd_pkg::CNT_W-1:0]         px_cnt;
	logic [trd_pkg::CNT_W-1:0]         hdr_cnt;
	logic                              acc;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign hdr_cnt  = (data_byte & trd_pkg::COUNT_MASK) + trd_pkg::CNT_W'(1);

	always_comb begin
		// new image clears packet state ahead of this byte
		hdr_c    = new_image ? 1'b1 : hdr_q;
		lit_c    = new_image ? '0 : lit_q;
		rep_c    = new_image ? '0 : rep_q;
		phase_c  = new_image ? 2'd0 : phase_q;
		gather_c = new_image ? '0 : gather_q;

		hdr_d    = hdr_c;
		lit_d    = lit_c;
		rep_d    = rep_c;
		phase_d  = phase_c;
		gather_d = gather_c;
		px       = 1'b0;
		px_cnt   = trd_pkg::CNT_W'(1);

		if (rle_mode && hdr_c) begin
			if ((data_byte & trd_pkg::REPEAT_FLAG) != 8'h00) begin
				rep_d = hdr_cnt;
				lit_d = '0;
			end else begin
				lit_d = hdr_cnt;
				rep_d = '0;
			end
			hdr_d   = 1'b0;
			phase_d = 2'd0;
		end else begin
			gather_d = {gather_c[trd_pkg::COLOR_W-9:0], data_byte};
			if (phase_c < 2'd2) begin
				phase_d = phase_c + 2'd1;
			end else begin
				phase_d = 2'd0;
				px      = 1'b1;
				if (rle_mode) begin
					if (rep_c != '0) begin
						px_cnt = rep_c;
						rep_d  = '0;
						hdr_d  = 1'b1;
					end else begin
						lit_d = (lit_c != '0) ? lit_c - trd_pkg::CNT_W'(1) : lit_c;
						if (lit_d == '0) begin
							hdr_d = 1'b1;
						end
					end
				end
			end
		end
	end

	assign push            = acc && (new_image || px);
	assign push_cmd.clr    = new_image;
	assign push_cmd.has_px = px;
	assign push_cmd.color  = gather_d;
	assign push_cmd.count  = px_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= 1'b1;
			lit_q    <= '0;
			rep_q    <= '0;
			phase_q  <= 2'd0;
			gather_q <= '0;
		end else if (acc) begin
			hdr_q    <= hdr_d;
			lit_q    <= lit_d;
			rep_q    <= rep_d;
			phase_q  <= phase_d;
			gather_q <= gather_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/trd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// trd_cmd_fifo
// Short command queue between the byte front end and the segment back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire trd_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output trd_pkg::cmd_t      head_cmd,
	output logic               full,
	output logic               empty
);

	trd_pkg::cmd_t                  mem_q [trd_pkg::QUEUE_DEPTH];
	logic [trd_pkg::PTR_W-1:0]      wr_ptr_q;
	logic [trd_pkg::PTR_W-1:0]      rd_ptr_q;
	logic [trd_pkg::LVL_W-1:0]      level_q;

	assign full     = (level_q == trd_pkg::LVL_W'(trd_pkg::QUEUE_DEPTH));
	assign empty    = (level_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + trd_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + trd_pkg::PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + trd_pkg::LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - trd_pkg::LVL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back
// Segment back end: splits runs at line ends, tracks position, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [trd_pkg::COORD_BITS-1:0]    line_width,
	input  wire logic [trd_pkg::COORD_BITS-1:0]    line_count,
	input  wire logic                              q_empty,
	input  wire trd_pkg::cmd_t                     q_head,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [31:0]                            pixel_color,
	output logic [7:0]                             run_length,
	output logic [trd_pkg::COORD_BITS-1:0]         x_start,
	output logic [trd_pkg::COORD_BITS-1:0]         row_index,
	output logic                                   end_of_line,
	output logic                                   end_of_image,
	output logic                                   last_result
);

	localparam int CB = trd_pkg::COORD_BITS;

	logic                              busy_q;
	logic [trd_pkg::COLOR_W-1:0]       color_q;
	logic [trd_pkg::CNT_W-1:0]         cnt_q;
	logic [CB-1:0]                     col_q;
	logic [CB-1:0]                     row_q;
	logic                              done_q;
	logic                              out_valid_q;
	logic [31:0]                       color_out_q;
	logic [7:0]                        len_q;
	logic [CB-1:0]                     x_q;
	logic [CB-1:0]                     y_q;
	logic                              eol_q;
	logic                              eoi_q;
	logic                              last_q;

	logic [CB-1:0]                     w_eff;
	logic [CB-1:0]                     h_eff;
	logic [CB-1:0]                     rem;
	logic [CB-1:0]                     cnt_ext;
	logic [CB-1:0]                     seg;
	logic                              eol;
	logic                              eoi;
	logic [CB:0]                       row_inc;
	logic                              seg_last;
	logic                              out_free;
	logic                              emit;
	logic                              finish;

	assign w_eff    = (line_width < trd_pkg::MIN_WIDTH) ? trd_pkg::MIN_WIDTH : line_width;
	assign h_eff    = (line_count == '0) ? CB'(1) : line_count;
	// a column left past the line end by a width change closes the line next pixel
	assign rem      = (col_q < w_eff) ? (w_eff - col_q) : CB'(1);
	assign cnt_ext  = CB'(cnt_q);
	assign seg      = (cnt_ext < rem) ? cnt_ext : rem;
	assign eol      = (seg == rem);
	assign row_inc  = {1'b0, row_q} + (CB+1)'(1);
	assign eoi      = eol && (row_inc >= {1'b0, h_eff});
	assign seg_last = (seg == cnt_ext) || eoi;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = busy_q && out_free && !done_q;
	// past the image end the rest of a run is dropped
	assign finish   = busy_q && (done_q || (out_free && seg_last));
	assign q_pop    = !q_empty && (!busy_q || finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			color_q     <= '0;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			color_out_q <= '0;
			len_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			eol_q       <= 1'b0;
			eoi_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (emit) begin
				cnt_q <= cnt_q - seg[trd_pkg::CNT_W-1:0];
				if (eol) begin
					col_q <= '0;
					row_q <= row_inc[CB-1:0];
					if (eoi) begin
						done_q <= 1'b1;
					end
				end else begin
					col_q <= col_q + seg;
				end
			end
			if (finish) begin
				busy_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q  <= q_head.has_px;
				color_q <= q_head.color;
				cnt_q   <= q_head.count;
				if (q_head.clr) begin
					col_q  <= '0;
					row_q  <= '0;
					done_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				color_out_q <= {trd_pkg::ALPHA_BYTE, color_q};
				len_q       <= seg[7:0];
				x_q         <= col_q;
				y_q         <= row_q;
				eol_q       <= eol;
				eoi_q       <= eoi;
				last_q      <= seg_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_color  = color_out_q;
	assign run_length   = len_q;
	assign x_start      = x_q;
	assign row_index    = y_q;
	assign end_of_line  = eol_q;
	assign end_of_image = eoi_q;
	assign last_result  = last_q;

endmodule

`default_nettype wire
